@@ rtl/assert_macros.svh @@
// assertion helpers, clocked on i_clk and disabled while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)

`define ASSERT_NEVER(label, cond, msg)

`endif

`endif

@@ rtl/udpsc_pkg.sv @@
`default_nettype none

package udpsc_pkg;

    localparam int HDR_BYTES = 8;
    localparam int LEN_W     = 11;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = 2;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [1:0] ENT_PAYLOAD     = 2'd0;
    localparam logic [1:0] ENT_PAYLOAD_HDR = 2'd1;
    localparam logic [1:0] ENT_ERROR       = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [7:0]       pbyte;
        logic [15:0]      sport;
        logic [15:0]      dport;
        logic [LEN_W-1:0] seglen;
        logic [15:0]      csum;
        logic [31:0]      ip;
    } t_entry;

    typedef struct packed {
        logic            full;
        logic            empty;
        logic [Q_AW:0]   count;
    } t_q_stat;

endpackage

`default_nettype wire

@@ rtl/udpsc_front.sv @@
`default_nettype none

module udpsc_front
    import udpsc_pkg::*;
#(
    parameter int MAX_SEGMENT_BYTES = 1024
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_wr_en,
    input  wire logic [15:0]  i_cfg_wr_data,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [7:0]   i_data_byte,
    input  wire logic         i_last,
    input  wire logic [15:0]  i_dest_port,
    input  wire logic [31:0]  i_dest_ip,
    input  wire t_q_stat      i_q_stat,
    output logic              o_push,
    output t_entry            o_entry
);

    localparam int CW          = $clog2(MAX_SEGMENT_BYTES);
    localparam int MAX_PAYLOAD = MAX_SEGMENT_BYTES - HDR_BYTES;
    localparam int LW          = (CW + 1 > LEN_W) ? CW + 1 : LEN_W;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    logic [15:0]   r_src_port;
    logic [CW-1:0] r_count, n_count;
    logic [15:0]   r_sum, n_sum;
    logic [7:0]    r_held, n_held;
    logic          r_phase, n_phase;

    logic [CW-1:0] count_inc;
    logic          close_seg;
    logic [15:0]   word;
    logic [15:0]   sum_add;
    logic [LW-1:0] len_full;
    logic          accept;

    assign o_ready   = !i_q_stat.full;
    assign accept    = i_valid && o_ready;
    assign o_push    = accept;
    assign count_inc = r_count + CW'(1);
    assign close_seg = i_last || (count_inc >= CW'(MAX_PAYLOAD));
    assign word      = r_phase ? {i_data_byte, r_held} : {8'h00, i_data_byte};
    assign sum_add   = oc_add(r_sum, word);
    assign len_full  = LW'(count_inc) + LW'(HDR_BYTES);

    always_comb begin
        o_entry.pbyte  = i_data_byte;
        o_entry.sport  = r_src_port;
        o_entry.dport  = i_dest_port;
        o_entry.seglen = len_full[LEN_W-1:0];
        o_entry.csum   = ~sum_add;
        o_entry.ip     = i_dest_ip;
        if (r_src_port == 16'd0) begin
            o_entry.mode = ENT_ERROR;
        end else if (close_seg) begin
            o_entry.mode = ENT_PAYLOAD_HDR;
        end else begin
            o_entry.mode = ENT_PAYLOAD;
        end
    end

    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        n_held  = r_held;
        n_phase = r_phase;
        if (accept && r_src_port != 16'd0) begin
            if (close_seg) begin
                n_count = '0;
                n_sum   = '0;
                n_held  = '0;
                n_phase = 1'b0;
            end else begin
                n_count = count_inc;
                if (r_phase) begin
                    n_sum   = sum_add;
                    n_held  = '0;
                    n_phase = 1'b0;
                end else begin
                    n_held  = i_data_byte;
                    n_phase = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_port <= '0;
            r_count    <= '0;
            r_sum      <= '0;
            r_held     <= '0;
            r_phase    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_src_port <= i_cfg_wr_data;
            end
            r_count <= n_count;
            r_sum   <= n_sum;
            r_held  <= n_held;
            r_phase <= n_phase;
        end
    end

endmodule

`default_nettype wire

@@ rtl/udpsc_queue.sv @@
`default_nettype none

module udpsc_queue
    import udpsc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_entry  i_entry,
    input  wire logic    i_pop,
    output t_entry       o_entry,
    output t_q_stat      o_stat
);

    t_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;

    assign o_entry      = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (Q_AW+1)'(1);
                2'b01:   r_count <= r_count - (Q_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/udpsc_back.sv @@
`default_nettype none

module udpsc_back
    import udpsc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_entry  i_entry,
    input  wire t_q_stat i_q_stat,
    output logic         o_pop,
    output logic         o_valid,
    input  wire logic    i_ready,
    output logic [1:0]   o_kind,
    output logic [7:0]   o_payload_byte,
    output logic [15:0]  o_sport,
    output logic [15:0]  o_dport,
    output logic [LEN_W-1:0] o_seglen,
    output logic [15:0]  o_csum,
    output logic [31:0]  o_ip,
    output logic         o_last
);

    logic   r_valid;
    logic   r_hdr_phase;
    t_entry r_entry;
    logic   done;
    logic   is_hdr;

    assign is_hdr = r_hdr_phase;
    assign done   = r_valid && i_ready && (r_hdr_phase || r_entry.mode != ENT_PAYLOAD_HDR);
    assign o_pop  = (!r_valid || done) && !i_q_stat.empty;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_hdr_phase <= 1'b0;
        end else if (o_pop) begin
            r_valid     <= 1'b1;
            r_hdr_phase <= 1'b0;
        end else if (done) begin
            r_valid     <= 1'b0;
            r_hdr_phase <= 1'b0;
        end else if (r_valid && i_ready) begin
            r_hdr_phase <= 1'b1;
        end
    end

    always_comb begin
        o_valid        = r_valid;
        o_ip           = r_entry.ip;
        o_kind         = KIND_PAYLOAD;
        o_payload_byte = '0;
        o_sport        = '0;
        o_dport        = '0;
        o_seglen       = '0;
        o_csum         = '0;
        o_last         = 1'b1;
        unique case (r_entry.mode)
            ENT_ERROR: begin
                o_kind = KIND_ERROR;
            end
            ENT_PAYLOAD_HDR: begin
                if (is_hdr) begin
                    o_kind   = KIND_HEADER;
                    o_sport  = r_entry.sport;
                    o_dport  = r_entry.dport;
                    o_seglen = r_entry.seglen;
                    o_csum   = r_entry.csum;
                end else begin
                    o_payload_byte = r_entry.pbyte;
                    o_last         = 1'b0;
                end
            end
            default: begin
                o_payload_byte = r_entry.pbyte;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/udp_segment_checksum_framer.sv @@
// channel   dir  handshake              tdata / tuser / tlast
// s_axis    in   tvalid/tready          byte, dest_port, dest_ip / - / last_of_message
// m_axis    out  tvalid/tready          byte..target_ip / kind / end_of_run
// cfg       in   i_cfg_wr_en            source_port, no read-back
//
// one input item per cycle while the queue is not full; a segment-closing item adds a header output item
// input passes through the combinational classify logic into a 4-entry queue, then the output register
// the one's complement add accumulates payload bytes as 16-bit word pairs in the front stage
// synchronous active-low reset clears segment state, source port and queue
// either side may stall; the queue keeps the front running while the output waits
`default_nettype none

`include "assert_macros.svh"

module udp_segment_checksum_framer
    import udpsc_pkg::*;
#(
    parameter int MAX_SEGMENT_BYTES = 1024
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_wr_en,
    input  wire logic [15:0]   i_cfg_wr_data,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [55:0]   s_axis_tdata,  // data_byte, dest_port, dest_ip
    input  wire logic          s_axis_tlast,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // payload_byte, header_source_port, header_dest_port, segment_length,
    // segment_checksum, target_ip, zero pad
    output logic [103:0]       m_axis_tdata,
    output logic [1:0]         m_axis_tuser,  // kind
    output logic               m_axis_tlast
);

    t_entry           w_push_entry;
    t_entry           w_head_entry;
    t_q_stat          w_q_stat;
    logic             w_push;
    logic             w_pop;
    logic [7:0]       w_pbyte;
    logic [15:0]      w_sport;
    logic [15:0]      w_dport;
    logic [LEN_W-1:0] w_seglen;
    logic [15:0]      w_csum;
    logic [31:0]      w_ip;

    udpsc_front #(
        .MAX_SEGMENT_BYTES(MAX_SEGMENT_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_data_byte   (s_axis_tdata[7:0]),
        .i_last        (s_axis_tlast),
        .i_dest_port   (s_axis_tdata[23:8]),
        .i_dest_ip     (s_axis_tdata[55:24]),
        .i_q_stat      (w_q_stat),
        .o_push        (w_push),
        .o_entry       (w_push_entry)
    );

    udpsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_entry (w_head_entry),
        .o_stat  (w_q_stat)
    );

    udpsc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_entry        (w_head_entry),
        .i_q_stat       (w_q_stat),
        .o_pop          (w_pop),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_kind         (m_axis_tuser),
        .o_payload_byte (w_pbyte),
        .o_sport        (w_sport),
        .o_dport        (w_dport),
        .o_seglen       (w_seglen),
        .o_csum         (w_csum),
        .o_ip           (w_ip),
        .o_last         (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, w_ip, w_csum, w_seglen, w_dport, w_sport, w_pbyte};

    `ASSERT_CLK(a_hdr_follows, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tuser == KIND_HEADER, "header item missing after closing payload")
    `ASSERT_CLK(a_err_last, m_axis_tvalid && m_axis_tuser == KIND_ERROR |-> m_axis_tlast, "error item without end of run")
    `ASSERT_NEVER(a_q_over, w_q_stat.count > (Q_AW+1)'(Q_DEPTH), "queue count above depth")
    `ASSERT_NEVER(a_pop_empty, w_pop && w_q_stat.empty, "pop from empty queue")

endmodule

`default_nettype wire
